/* rtl/gwm_pkg.sv */
// Package for the glob wildcard matcher: item codes, element kinds and
// pattern character constants. No dependencies.
package gwm_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_BEGIN  = 2'd2,
        FUNC_TEXT   = 2'd3
    } func_t;

    // Stored pattern element kinds
    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY     = 2'd1,
        KIND_STAR    = 2'd2
    } kind_t;

    localparam logic [7:0] CH_ANY    = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_ESCAPE = 8'h5C;  // backslash

endpackage

/* rtl/glob_wildcard_matcher.sv */
// Glob wildcard matcher top level: element store, NFA position vector and
// result register. Depends on gwm_pkg and gwm_closure.
//
// Matches a byte stream against a whole-string glob pattern. Load the pattern
// with append beats ('?' any byte, '*' any run, backslash makes the next byte
// literal), start a text with a begin beat, then send text bytes. Every input
// beat returns one result beat: matched is 1 when the text since the last
// begin matches the entire pattern, overflow is 1 when the pattern outgrew
// MAX_ELEMENTS since the last clear (matched is then forced to 0, as it is
// while a trailing backslash is pending). One beat is taken per cycle while
// the result slot is empty or being drained, and its result is registered
// for the next cycle. The position vector's star closure runs through a
// log-depth prefix network of $clog2(MAX_ELEMENTS+1) levels. The result
// register decouples the sides, so a stalled result blocks new beats.
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // Element store: written at the fill pointer, each entry read by its own lane
    kind_t                  kind_reg [MAX_ELEMENTS];
    logic [7:0]             byte_reg [MAX_ELEMENTS];

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   esc_reg, esc_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_ELEMENTS:0]  act_reg, act_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   matched_reg, matched_next;
    logic                   overflow_reg;

    logic                   in_fire;
    logic                   wr_en;
    kind_t                  wr_kind;
    logic [7:0]             wr_byte;
    logic [IDX_W-1:0]       wr_idx;

    logic [MAX_ELEMENTS-1:0] elem_en;
    logic [MAX_ELEMENTS-1:0] star_mask;
    logic [MAX_ELEMENTS:0]   step_vec;
    logic [MAX_ELEMENTS:0]   closure_in;
    logic [MAX_ELEMENTS:0]   closure_out;

    // Accept a beat whenever the result slot is free or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign wr_idx   = count_reg[IDX_W-1:0];

    // Per-element lanes: live flag, star flag and one-byte NFA step
    always_comb
    begin
        step_vec = '0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            elem_en[i]   = (CNT_W'(i) < count_reg);
            star_mask[i] = elem_en[i] && (kind_reg[i] == KIND_STAR);
            if (elem_en[i] && act_reg[i])
            begin
                if (kind_reg[i] == KIND_STAR)
                    step_vec[i] = 1'b1;
                if ((kind_reg[i] == KIND_ANY)
                    || ((kind_reg[i] == KIND_LITERAL) && (byte_reg[i] == byte_value)))
                    step_vec[i+1] = 1'b1;
            end
        end
    end

    // Begin seeds position zero; a text byte feeds the stepped vector
    assign closure_in = (func_t'(func) == FUNC_BEGIN)
                      ? (MAX_ELEMENTS+1)'(1) : step_vec;

    gwm_closure #(
        .NUM_ELEM (MAX_ELEMENTS)
    ) u_closure (
        .vec_in    (closure_in),
        .star_mask (star_mask),
        .vec_out   (closure_out)
    );

    // Next state for the accepted beat
    always_comb
    begin
        count_next = count_reg;
        esc_next   = esc_reg;
        ovf_next   = ovf_reg;
        act_next   = act_reg;
        wr_en      = 1'b0;
        wr_kind    = KIND_LITERAL;
        wr_byte    = byte_value;

        if (in_fire)
        begin
            unique case (func_t'(func))
                FUNC_CLEAR:
                begin
                    count_next = '0;
                    esc_next   = 1'b0;
                    ovf_next   = 1'b0;
                    act_next   = '0;
                end
                FUNC_APPEND:
                begin
                    priority if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        wr_en    = 1'b1;
                        wr_kind  = KIND_LITERAL;
                    end
                    else if (byte_value == CH_ESCAPE)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (byte_value == CH_ANY)
                    begin
                        wr_en   = 1'b1;
                        wr_kind = KIND_ANY;
                    end
                    else if (byte_value == CH_STAR)
                    begin
                        wr_en   = 1'b1;
                        wr_kind = KIND_STAR;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_kind = KIND_LITERAL;
                    end
                    // Drop an element that does not fit and flag it
                    if (wr_en && (count_reg >= CNT_W'(MAX_ELEMENTS)))
                    begin
                        wr_en    = 1'b0;
                        ovf_next = 1'b1;
                    end
                    if (wr_en)
                        count_next = count_reg + CNT_W'(1);
                end
                FUNC_BEGIN:
                begin
                    act_next = closure_out;
                end
                FUNC_TEXT:
                begin
                    act_next = closure_out;
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    // Result of the beat, taken from the state it leaves behind
    assign matched_next   = act_next[count_next] && !esc_next && !ovf_next;
    assign out_valid_next = in_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            esc_reg       <= esc_next;
            ovf_reg       <= ovf_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: store entries and result fields
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_reg[wr_idx] <= wr_kind;
            byte_reg[wr_idx] <= wr_byte;
        end
        if (in_fire)
        begin
            matched_reg  <= matched_next;
            overflow_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

endmodule

/* rtl/gwm_closure.sv */
// Star-closure network: log-depth parallel-prefix propagation of active
// positions across runs of star elements. Depends on nothing.
module gwm_closure #(
    parameter int NUM_ELEM = 32
) (
    input  logic [NUM_ELEM:0]   vec_in,
    input  logic [NUM_ELEM-1:0] star_mask,
    output logic [NUM_ELEM:0]   vec_out
);

    localparam int NUM_POS = NUM_ELEM + 1;
    localparam int LEVELS  = $clog2(NUM_POS);

    // Position i is reached from i-1 when element i-1 is a star.
    logic [NUM_POS-1:0] gen_lvl  [LEVELS+1];
    logic [NUM_POS-1:0] prop_lvl [LEVELS+1];

    assign gen_lvl[0]  = vec_in;
    assign prop_lvl[0] = {star_mask, 1'b0};

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        localparam int DIST = 1 << l;
        for (genvar i = 0; i < NUM_POS; i++) begin : g_pos
            if (i >= DIST) begin : g_comb
                assign gen_lvl[l+1][i]  = gen_lvl[l][i]
                                        | (prop_lvl[l][i] & gen_lvl[l][i-DIST]);
                assign prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i-DIST];
            end
            else begin : g_pass
                assign gen_lvl[l+1][i]  = gen_lvl[l][i];
                assign prop_lvl[l+1][i] = prop_lvl[l][i];
            end
        end
    end

    assign vec_out = gen_lvl[LEVELS];

endmodule

/* rtl/gwm_checker.sv */
// Port-level checker for the glob wildcard matcher, bound to the top level.
// Depends on gwm_pkg.
module gwm_checker
    import gwm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] func,
    input logic [7:0] byte_value,
    input logic       out_valid,
    input logic       out_ready,
    input logic       matched,
    input logic       overflow
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(overflow))
        else $error("result beat changed while stalled");

    // Every accepted beat yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // A clear drops the match and the overflow flag
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_CLEAR) |=> !matched && !overflow)
        else $error("clear did not reset the result");

    // Overflow forces no match
    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && overflow))
        else $error("match reported with overflow set");

    // An empty result slot never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);
